### design/ptc_pkg.sv
// ptc_pkg: shared types and constants for the prefix tree counter.
// Holds the item structs, request and status codes and the sequencer states.
// Depends on nothing; every other design file but ptc_ram refers to it by scoped names.
package ptc_pkg;

   // Fixed field widths of the request and result items.
   localparam int OP_W     = 3;
   localparam int LETTER_W = 5;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;

   // Alphabet size and the highest legal letter code.
   localparam int ALPHA = 26;
   localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

   // Request codes.
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_EXACT  = 3'd1;
   localparam logic [OP_W-1:0] OP_PREFIX = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

   // Largest count the result field can show; stored counts above it saturate.
   localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;
   localparam logic [31:0] SAT_LIMIT = 32'd65535;

   typedef struct packed {
      logic [OP_W-1:0]     req_type;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   // A finished word (or a clear) handed from the letter buffer to the engine.
   typedef struct packed {
      logic            fire;
      logic [OP_W-1:0] op;
      logic            too_long;
   } word_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_ROOT,
      S_COUNT,
      S_EDGE,
      S_CHILD,
      S_DECIDE
   } engine_state_type;

endpackage

### design/ptc_ram.sv
// ptc_ram: generic single-write, single-read RAM with a registered read port.
// A read of the address written in the same cycle returns the old contents.
// Depends on nothing.
module ptc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ptc_word_buf.sv
// ptc_word_buf: collects the letters of a word, one item at a time.
// Keeps the word length and the letter RAM and flags each finished word.
// Depends on ptc_pkg and ptc_ram.
module ptc_word_buf #(
   parameter int MAX_LEN = 32,
   localparam int IDX_W  = $clog2(MAX_LEN + 1),
   localparam int BUF_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  ptc_pkg::req_item_type          req_item,
   input  logic [BUF_AW-1:0]              rd_addr,
   output logic [ptc_pkg::LETTER_W-1:0]   rd_letter,
   output ptc_pkg::word_cmd_type          word_cmd,
   output logic [IDX_W-1:0]               word_len
);

   localparam int LEN_W = $clog2(MAX_LEN + 2);

   logic [LEN_W-1:0]              len_ff, len_in;
   logic [LEN_W-1:0]              grown_len;
   logic                          room;
   logic                          is_clear;
   logic                          wr_en;
   logic [ptc_pkg::LETTER_W-1:0]  letter_sat;

   // Out-of-range letter codes fold onto the last letter.
   assign letter_sat = (req_item.letter > ptc_pkg::LETTER_MAX) ? ptc_pkg::LETTER_MAX
                                                               : req_item.letter;
   assign is_clear  = (req_item.req_type == ptc_pkg::OP_CLEAR);
   assign room      = (len_ff < LEN_W'(MAX_LEN));
   // Once full, the length parks one past the limit to mark the word too long.
   assign grown_len = room ? (len_ff + LEN_W'(1)) : LEN_W'(MAX_LEN + 1);
   assign wr_en     = accept && !is_clear && room;

   // Length of the word being collected.
   always_comb begin
      len_in = len_ff;
      if (accept) begin
         if (is_clear || req_item.last) begin
            len_in = '0;
         end else begin
            len_in = grown_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // A word ends with its last letter; a clear fires at once.
   always_comb begin
      word_cmd.fire     = accept && (is_clear || req_item.last);
      word_cmd.op       = req_item.req_type;
      word_cmd.too_long = (grown_len > LEN_W'(MAX_LEN));
   end

   assign word_len = grown_len[IDX_W-1:0];

   ptc_ram #(
      .WIDTH (ptc_pkg::LETTER_W),
      .DEPTH (MAX_LEN)
   ) u_letters (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[BUF_AW-1:0]),
      .wr_data (letter_sat),
      .rd_addr (rd_addr),
      .rd_data (rd_letter)
   );

endmodule

### design/ptc_engine.sv
// ptc_engine: sequencer that walks the trie one letter per step.
// Owns the edge table, the pass and end count tables and the node allocator.
// Depends on ptc_pkg and ptc_ram.
module ptc_engine #(
   parameter int NODES      = 1024,
   parameter int MAX_LEN    = 32,
   parameter int COUNT_BITS = 16,
   localparam int IDX_W     = $clog2(MAX_LEN + 1),
   localparam int BUF_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ptc_pkg::word_cmd_type          word_cmd,
   input  logic [IDX_W-1:0]               word_len,
   output logic [BUF_AW-1:0]              buf_rd_addr,
   input  logic [ptc_pkg::LETTER_W-1:0]   buf_letter,
   output logic                           busy,
   output logic                           rsp_valid,
   output ptc_pkg::rsp_item_type          rsp_item
);

   localparam int NODE_W      = $clog2(NODES);
   localparam int FREE_W      = $clog2(NODES + 1);
   localparam int CHILD_DEPTH = NODES * ptc_pkg::ALPHA;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam int SUM_W       = $clog2(NODES + MAX_LEN + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   ptc_pkg::engine_state_type state_ff, state_in;

   logic                        upd_ff, upd_in;       // 0: checking walk, 1: update walk
   logic [ptc_pkg::OP_W-1:0]    op_ff, op_in;
   logic [IDX_W-1:0]            len_ff, len_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            missing_ff, missing_in;
   logic [NODE_W-1:0]           cur_ff, cur_in;
   logic [CHILD_AW-1:0]         slot_ff, slot_in;
   logic                        over_ff, over_in;
   logic                        root_ff, root_in;
   logic [FREE_W-1:0]           free_ff, free_in;
   logic [CHILD_AW-1:0]         clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptc_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;

   // Table ports.
   logic                        child_wr_en;
   logic [CHILD_AW-1:0]         child_wr_addr;
   logic [NODE_W-1:0]           child_wr_data;
   logic [CHILD_AW-1:0]         slot_calc;
   logic [NODE_W-1:0]           child_rd_data;
   logic                        pass_wr_en, end_wr_en;
   logic [NODE_W-1:0]           cnt_wr_addr, cnt_rd_addr;
   logic [COUNT_BITS-1:0]       pass_wr_data, end_wr_data;
   logic [COUNT_BITS-1:0]       pass_rd, end_rd;

   // Step arithmetic shared by all operations.
   logic                        at_end;
   logic                        no_edge;
   logic [COUNT_BITS-1:0]       pass_inc, pass_dec, end_inc, end_dec;
   logic [COUNT_BITS-1:0]       count_pick;
   logic [31:0]                 pick_wide;
   logic [ptc_pkg::COUNT_W-1:0] count_sat;
   logic [SUM_W-1:0]            pool_sum;
   logic                        pool_fail;
   logic [NODE_W-1:0]           nxt_node;

   assign slot_calc = CHILD_AW'(cur_ff) * CHILD_AW'(ptc_pkg::ALPHA) + CHILD_AW'(buf_letter);
   assign at_end    = (idx_ff == len_ff);
   assign no_edge   = (child_rd_data == '0);
   assign pass_inc  = pass_rd + COUNT_BITS'(1);
   assign end_inc   = end_rd + COUNT_BITS'(1);
   assign pass_dec  = (pass_rd == '0) ? '0 : (pass_rd - COUNT_BITS'(1));
   assign end_dec   = (end_rd == '0) ? '0 : (end_rd - COUNT_BITS'(1));
   assign count_pick = (op_ff == ptc_pkg::OP_EXACT) ? end_rd : pass_rd;
   assign pick_wide  = 32'(count_pick);
   assign count_sat  = (pick_wide > ptc_pkg::SAT_LIMIT) ? ptc_pkg::COUNT_SAT
                                                        : pick_wide[ptc_pkg::COUNT_W-1:0];
   assign pool_sum   = SUM_W'(free_ff) + SUM_W'(missing_ff);
   assign pool_fail  = (pool_sum > SUM_W'(NODES));
   // During an insert update a missing edge takes the next free node.
   assign nxt_node   = no_edge ? free_ff[NODE_W-1:0] : child_rd_data;

   // The letter RAM always reads the letter of the step about to run.
   assign buf_rd_addr = idx_in[BUF_AW-1:0];

   // Sequencer: next state, table writes and the result.
   always_comb begin
      state_in      = state_ff;
      upd_in        = upd_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      missing_in    = missing_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      over_in       = over_ff;
      root_in       = root_ff;
      free_in       = free_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      child_wr_en   = 1'b0;
      child_wr_addr = slot_ff;
      child_wr_data = '0;
      pass_wr_en    = 1'b0;
      end_wr_en     = 1'b0;
      cnt_wr_addr   = cur_ff;
      pass_wr_data  = '0;
      end_wr_data   = '0;
      cnt_rd_addr   = cur_ff;

      case (state_ff)
         ptc_pkg::S_IDLE: begin
            if (word_cmd.fire) begin
               op_in   = word_cmd.op;
               len_in  = word_len;
               idx_in  = '0;
               upd_in  = 1'b0;
               over_in = 1'b0;
               rsp_item_in.count  = '0;
               rsp_item_in.status = ptc_pkg::ST_OK;
               if (word_cmd.op == ptc_pkg::OP_CLEAR) begin
                  rsp_valid_in = 1'b1;
                  clr_in       = '0;
                  free_in      = FREE_W'(2);
                  state_in     = ptc_pkg::S_CLEAR;
               end else if (word_cmd.too_long) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ptc_pkg::ST_TOO_LONG;
               end else if (word_cmd.op == ptc_pkg::OP_INSERT ||
                            word_cmd.op == ptc_pkg::OP_EXACT ||
                            word_cmd.op == ptc_pkg::OP_PREFIX ||
                            word_cmd.op == ptc_pkg::OP_ERASE) begin
                  state_in = ptc_pkg::S_ROOT;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         // Sweep every edge and count entry back to zero.
         ptc_pkg::S_CLEAR: begin
            child_wr_en   = 1'b1;
            child_wr_addr = clr_ff;
            if (clr_ff < CHILD_AW'(NODES)) begin
               pass_wr_en  = 1'b1;
               end_wr_en   = 1'b1;
               cnt_wr_addr = clr_ff[NODE_W-1:0];
            end
            if (clr_ff == CHILD_AW'(CHILD_DEPTH - 1)) begin
               state_in = ptc_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + CHILD_AW'(1);
            end
         end

         // Start a walk at the root.
         ptc_pkg::S_ROOT: begin
            cnt_rd_addr = NODE_W'(1);
            cur_in      = NODE_W'(1);
            idx_in      = '0;
            root_in     = 1'b1;
            state_in    = ptc_pkg::S_COUNT;
         end

         // Counts of the current node are on the read ports.
         ptc_pkg::S_COUNT: begin
            state_in = ptc_pkg::S_EDGE;
            if (!upd_ff) begin
               if (op_ff == ptc_pkg::OP_INSERT) begin
                  over_in = over_ff || (pass_rd == COUNT_MAX) ||
                            (at_end && (end_rd == COUNT_MAX));
                  if (at_end) begin
                     missing_in = '0;
                     state_in   = ptc_pkg::S_DECIDE;
                  end
               end else if (op_ff == ptc_pkg::OP_ERASE) begin
                  if (at_end) begin
                     if (end_rd == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.count  = '0;
                        rsp_item_in.status = ptc_pkg::ST_OK;
                        state_in           = ptc_pkg::S_IDLE;
                     end else begin
                        upd_in   = 1'b1;
                        state_in = ptc_pkg::S_ROOT;
                     end
                  end
               end else if (at_end) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.count  = count_sat;
                  rsp_item_in.status = ptc_pkg::ST_OK;
                  state_in           = ptc_pkg::S_IDLE;
               end
            end else if (op_ff == ptc_pkg::OP_INSERT) begin
               pass_wr_en   = 1'b1;
               pass_wr_data = pass_inc;
               if (at_end) begin
                  end_wr_en          = 1'b1;
                  end_wr_data        = end_inc;
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.count  = '0;
                  rsp_item_in.status = ptc_pkg::ST_OK;
                  state_in           = ptc_pkg::S_IDLE;
               end
            end else begin
               // Erase update: the first node that drops to zero loses its edge.
               pass_wr_en   = 1'b1;
               pass_wr_data = pass_dec;
               if (pass_dec == '0 && !root_ff) begin
                  child_wr_en        = 1'b1;
                  child_wr_addr      = slot_ff;
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.count  = '0;
                  rsp_item_in.status = ptc_pkg::ST_OK;
                  state_in           = ptc_pkg::S_IDLE;
               end else if (at_end) begin
                  end_wr_en          = 1'b1;
                  end_wr_data        = end_dec;
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.count  = '0;
                  rsp_item_in.status = ptc_pkg::ST_OK;
                  state_in           = ptc_pkg::S_IDLE;
               end
            end
         end

         // Letter is ready: look up the edge out of the current node.
         ptc_pkg::S_EDGE: begin
            slot_in  = slot_calc;
            root_in  = 1'b0;
            state_in = ptc_pkg::S_CHILD;
         end

         // Edge target is on the read port.
         ptc_pkg::S_CHILD: begin
            if (upd_ff && op_ff == ptc_pkg::OP_INSERT) begin
               if (no_edge) begin
                  child_wr_en   = 1'b1;
                  child_wr_addr = slot_ff;
                  child_wr_data = free_ff[NODE_W-1:0];
                  free_in       = free_ff + FREE_W'(1);
               end
               cnt_rd_addr = nxt_node;
               cur_in      = nxt_node;
               idx_in      = idx_ff + IDX_W'(1);
               state_in    = ptc_pkg::S_COUNT;
            end else if (no_edge) begin
               if (op_ff == ptc_pkg::OP_INSERT) begin
                  missing_in = len_ff - idx_ff;
                  state_in   = ptc_pkg::S_DECIDE;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.count  = '0;
                  rsp_item_in.status = ptc_pkg::ST_OK;
                  state_in           = ptc_pkg::S_IDLE;
               end
            end else begin
               cnt_rd_addr = child_rd_data;
               cur_in      = child_rd_data;
               idx_in      = idx_ff + IDX_W'(1);
               state_in    = ptc_pkg::S_COUNT;
            end
         end

         // Insert: pool and overflow checks before anything is written.
         ptc_pkg::S_DECIDE: begin
            rsp_item_in.count = '0;
            if (pool_fail) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = ptc_pkg::ST_POOL_FULL;
               state_in           = ptc_pkg::S_IDLE;
            end else if (over_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = ptc_pkg::ST_OVERFLOW;
               state_in           = ptc_pkg::S_IDLE;
            end else begin
               upd_in   = 1'b1;
               state_in = ptc_pkg::S_ROOT;
            end
         end

         default: begin
            state_in = ptc_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptc_pkg::S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= FREE_W'(2);
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk registers and the result item.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      missing_ff  <= missing_in;
      cur_ff      <= cur_in;
      slot_ff     <= slot_in;
      over_ff     <= over_in;
      root_ff     <= root_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = (state_ff != ptc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   ptc_ram #(
      .WIDTH (NODE_W),
      .DEPTH (CHILD_DEPTH)
   ) u_child (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_addr (slot_calc),
      .rd_data (child_rd_data)
   );

   ptc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NODES)
   ) u_pass (
      .clock   (clock),
      .wr_en   (pass_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (pass_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (pass_rd)
   );

   ptc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NODES)
   ) u_end (
      .clock   (clock),
      .wr_en   (end_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (end_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (end_rd)
   );

endmodule

### design/prefix_tree_counter.sv
// prefix_tree_counter: top level of the lowercase word trie with counts.
// Joins the letter buffer and the walk engine; assertions sit at the end.
// Depends on ptc_pkg, ptc_word_buf and ptc_engine.

// Words arrive one letter per item; an item is taken when start is high and
// busy is low. A letter that does not end a word is only buffered and leaves
// busy low. The item that ends a word (last high) starts the operation, and
// its single result appears on rsp_item with rsp_valid high for exactly one
// cycle; the receiver cannot stall it, so it must take every result as it
// comes. Each step of a walk visits one node (letter read, edge read, count
// read) through one shared edge memory and two count memories. A query makes
// one walk, an insert a checking walk, a decision, then an update walk, and an
// erase of a stored word a checking walk, then an update walk; a query or
// erase of an absent word ends at its first missing edge. Too long words and
// undefined request codes answer without a walk. A clear item, and reset,
// sweep the edge memory one entry per cycle while busy stays high; the clear
// result is given at the start of that sweep.
module prefix_tree_counter #(
   parameter int NODES      = 1024,
   parameter int MAX_LEN    = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ptc_pkg::req_item_type req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output ptc_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W  = $clog2(MAX_LEN + 1);
   localparam int BUF_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic                          req_accept;
   ptc_pkg::word_cmd_type         word_cmd;
   logic [IDX_W-1:0]              word_len;
   logic [BUF_AW-1:0]             buf_rd_addr;
   logic [ptc_pkg::LETTER_W-1:0]  buf_letter;

   // An item is taken whenever start is high and the engine is idle.
   assign req_accept = start && !busy;

   ptc_word_buf #(
      .MAX_LEN (MAX_LEN)
   ) u_word_buf (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req_item  (req_item),
      .rd_addr   (buf_rd_addr),
      .rd_letter (buf_letter),
      .word_cmd  (word_cmd),
      .word_len  (word_len)
   );

   ptc_engine #(
      .NODES      (NODES),
      .MAX_LEN    (MAX_LEN),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .word_cmd    (word_cmd),
      .word_len    (word_len),
      .buf_rd_addr (buf_rd_addr),
      .buf_letter  (buf_letter),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

`ifndef SYNTH
   // A clear item always starts the sweep.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.req_type == ptc_pkg::OP_CLEAR) |=> busy)
      else $error("clear item did not start the sweep");

   // A letter inside a word is only buffered: no result, no busy time.
   a_letter_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_item.last && req_item.req_type != ptc_pkg::OP_CLEAR)
      |=> (!busy && !rsp_valid))
      else $error("mid-word letter produced a result or busy cycle");

   // A result comes only from an item just taken or from work in progress.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(req_accept) || $past(busy)))
      else $error("result without a word end or running operation");
`endif

endmodule

### tb/ptc_trie_checker.sv
`timescale 1ns / 1ps
// ptc_trie_checker: watches the item and result channels of the prefix tree counter.
// Keeps its own copy of the trie, predicts each result and compares it field by field.
// Depends on ptc_pkg for the item structs and the request and status codes.
module ptc_trie_checker #(
   parameter int NODES      = 1024,
   parameter int MAX_LEN    = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  ptc_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  ptc_pkg::rsp_item_type rsp_item,
   output int                    mismatches,
   output int                    pending
);
   import ptc_pkg::*;

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

   // Shadow trie: edges, counts, allocator and the word being collected.
   int unsigned         edge_tab [NODES*ALPHA];
   int unsigned         pass_cnt [NODES];
   int unsigned         end_cnt [NODES];
   int unsigned         next_node;
   logic [LETTER_W-1:0] word_buf [MAX_LEN];
   int unsigned         word_len;

   // Results still owed by the block, oldest first.
   rsp_item_type        answer_q[$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   // Empties every table and restarts node allocation after the root.
   function automatic void clear_trie();
      foreach (edge_tab[i]) edge_tab[i] = 0;
      foreach (pass_cnt[i]) begin
         pass_cnt[i] = 0;
         end_cnt[i] = 0;
      end
      next_node = 2;
   endfunction

   // Node reached by the buffered word, or 0 when an edge is missing.
   function automatic int unsigned walk_word(int unsigned len);
      int unsigned node;
      node = 1;
      for (int i = 0; i < len; i++) begin
         node = edge_tab[node*ALPHA + word_buf[i]];
         if (node == 0 || node >= NODES) return 0;
      end
      return node;
   endfunction

   // Checks pool space and count headroom first; only then adds the word.
   function automatic logic [STATUS_W-1:0] insert_word(int unsigned len);
      int unsigned cur;
      int unsigned nxt;
      int unsigned slot;
      int unsigned missing;
      bit          over;
      cur = 1;
      missing = 0;
      over = (pass_cnt[1] >= COUNT_MAX);
      for (int i = 0; i < len; i++) begin
         nxt = edge_tab[cur*ALPHA + word_buf[i]];
         if (nxt == 0 || nxt >= NODES) begin
            missing = len - i;
            break;
         end
         cur = nxt;
         if (pass_cnt[cur] >= COUNT_MAX) over = 1'b1;
      end
      if (missing == 0 && end_cnt[cur] >= COUNT_MAX) over = 1'b1;
      if (longint'(next_node) + longint'(missing) > longint'(NODES)) return ST_POOL_FULL;
      if (over) return ST_OVERFLOW;

      cur = 1;
      pass_cnt[cur]++;
      for (int i = 0; i < len; i++) begin
         slot = cur*ALPHA + word_buf[i];
         if (edge_tab[slot] == 0) begin
            edge_tab[slot] = next_node;
            next_node++;
         end
         cur = edge_tab[slot];
         pass_cnt[cur]++;
      end
      end_cnt[cur]++;
      return ST_OK;
   endfunction

   // Removes one copy of a stored word; the edge into the first node whose
   // pass count drops to zero is cut and the walk stops there.
   function automatic void erase_word(int unsigned len);
      int unsigned node;
      int unsigned cur;
      int unsigned nxt;
      int unsigned slot;
      node = walk_word(len);
      if (node == 0 || end_cnt[node] == 0) return;
      cur = 1;
      if (pass_cnt[cur] > 0) pass_cnt[cur]--;
      for (int i = 0; i < len; i++) begin
         slot = cur*ALPHA + word_buf[i];
         nxt = edge_tab[slot];
         if (pass_cnt[nxt] > 0) pass_cnt[nxt]--;
         if (pass_cnt[nxt] == 0) begin
            edge_tab[slot] = 0;
            return;
         end
         cur = nxt;
      end
      if (end_cnt[cur] > 0) end_cnt[cur]--;
   endfunction

   // Applies one accepted item; a word end or a clear yields one answer.
   task automatic apply_trie_item(input req_item_type item, output bit has_answer,
                                  output rsp_item_type answer);
      logic [OP_W-1:0]     op;
      logic [LETTER_W-1:0] ltr;
      int unsigned         len;
      int unsigned         node;
      int unsigned         hit;
      op = item.req_type;
      ltr = item.letter;
      has_answer = 1'b0;
      answer = '0;

      // A clear acts at once and drops any partial word.
      if (op == OP_CLEAR) begin
         clear_trie();
         word_len = 0;
         has_answer = 1'b1;
         return;
      end

      // Letters past the alphabet fold onto the last one; overlong words are flagged.
      if (ltr > LETTER_MAX) ltr = LETTER_MAX;
      if (word_len < MAX_LEN) begin
         word_buf[word_len] = ltr;
         word_len++;
      end else begin
         word_len = MAX_LEN + 1;
      end
      if (!item.last) return;

      len = word_len;
      word_len = 0;
      has_answer = 1'b1;
      if (len > MAX_LEN) begin
         answer.status = ST_TOO_LONG;
      end else begin
         case (op)
            OP_INSERT: begin
               answer.status = insert_word(len);
            end
            OP_EXACT, OP_PREFIX: begin
               node = walk_word(len);
               if (node != 0) begin
                  hit = (op == OP_EXACT) ? end_cnt[node] : pass_cnt[node];
                  answer.count = (hit > SAT_LIMIT) ? COUNT_SAT : hit[COUNT_W-1:0];
               end
            end
            OP_ERASE: begin
               erase_word(len);
            end
            default: begin
            end
         endcase
      end
   endtask

   // Results are compared before the item of the same edge is applied.
   always @(posedge clock) begin
      bit           has_answer;
      rsp_item_type answer;
      rsp_item_type want;
      if (reset) begin
         clear_trie();
         word_len = 0;
         answer_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (answer_q.size() == 0) begin
               $error("unexpected result: count %0d, status %0d",
                      rsp_item.count, rsp_item.status);
               mismatches++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_item.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_item.count);
                  mismatches++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            apply_trie_item(req_item, has_answer, answer);
            if (has_answer) answer_q.push_back(answer);
         end
      end
      pending = answer_q.size();
   end

endmodule

### tb/prefix_tree_counter_tb.sv
`timescale 1ns / 1ps
// prefix_tree_counter_tb: drives words and clears into the prefix tree counter.
// Depends on ptc_pkg, prefix_tree_counter and ptc_trie_checker, which does the checking.
module prefix_tree_counter_tb;
   import ptc_pkg::*;

   localparam int NODES       = 1024;
   localparam int MAX_LEN     = 32;
   localparam int COUNT_BITS  = 16;
   localparam int IDLE_PCT    = 12;
   localparam int STALL_LIMIT = 120000;
   localparam int DRAIN       = 300;
   localparam int RANDOM_ITEMS = 200;
   localparam int NOGAP_ITEMS = 100;
   localparam int TAIL_WORDS  = 10;

   // Request codes with no defined operation.
   localparam int OP_UNDEF_LO = 5;
   localparam int OP_UNDEF_HI = 7;

   logic         clock;
   logic         reset;
   logic         start;
   req_item_type req_item;
   logic         busy;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   int           mismatches;
   int           pending;

   logic [LETTER_W-1:0] word_q[$];
   int                  items_sent;
   bit                  idle_on;
   int                  stall_cycles;

   prefix_tree_counter #(
      .NODES(NODES),
      .MAX_LEN(MAX_LEN),
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_item(req_item),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   ptc_trie_checker #(
      .NODES(NODES),
      .MAX_LEN(MAX_LEN),
      .COUNT_BITS(COUNT_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .mismatches(mismatches),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run of cycles with no item and no result taken ends the test.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offers one item at a falling edge, after an occasional idle cycle, and
   // holds it until the block takes it.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                            input logic fin);
      req_item_type next_item;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         @(negedge clock);
      end
      next_item.req_type = op;
      next_item.letter = ltr;
      next_item.last = fin;
      start <= 1'b1;
      req_item <= next_item;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   // Sends the letters in word_q; only the final item's code selects the operation.
   task automatic send_word(input logic [OP_W-1:0] op);
      logic [OP_W-1:0] noise;
      for (int i = 0; i < word_q.size(); i++) begin
         noise = OP_W'($urandom_range(0, 7));
         if (noise == OP_CLEAR) noise = OP_ERASE;
         if (i == word_q.size() - 1) send_item(op, word_q[i], 1'b1);
         else send_item(noise, word_q[i], 1'b0);
      end
   endtask

   task automatic make_word(input int len, input int hi);
      word_q.delete();
      repeat (len) word_q.push_back(LETTER_W'($urandom_range(0, hi)));
   endtask

   // Mostly inserts and queries, with erases and a few undefined codes.
   function automatic logic [OP_W-1:0] pick_word_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return OP_INSERT;
      if (r < 58) return OP_EXACT;
      if (r < 76) return OP_PREFIX;
      if (r < 94) return OP_ERASE;
      return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
   endfunction

   // Mostly short words over a few letters so that words share prefixes; some are near or past the length limit.
   task automatic random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) make_word($urandom_range(30, 36), 31);
      else if (r < 20) make_word($urandom_range(1, 6), 31);
      else make_word($urandom_range(1, 4), 3);
      send_word(pick_word_op());
   endtask

   initial begin
      int random_end;
      int clears_left;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      items_sent = 0;
      idle_on = 1'b1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of the letter field, every operation, saturated
      // letters, erase down to a cut edge, erase of an absent word,
      // undefined codes, and a clear that drops a partial word.
      word_q = '{5'd0};
      send_word(OP_INSERT);
      word_q = '{5'd25, 5'd31};
      send_word(OP_INSERT);
      send_word(OP_INSERT);
      word_q = '{5'd25, 5'd25};
      send_word(OP_EXACT);
      word_q = '{5'd25};
      send_word(OP_PREFIX);
      word_q = '{5'd0};
      send_word(OP_EXACT);
      word_q = '{5'd25, 5'd30};
      send_word(OP_ERASE);
      word_q = '{5'd25, 5'd25};
      send_word(OP_ERASE);
      send_word(OP_EXACT);
      word_q = '{5'd7};
      send_word(OP_ERASE);
      word_q = '{5'd0};
      send_word(OP_W'(OP_UNDEF_LO));
      word_q = '{5'd1, 5'd2};
      send_word(OP_W'(OP_UNDEF_HI));
      send_item(OP_INSERT, 5'd3, 1'b0);
      send_item(OP_CLEAR, 5'd31, 1'b0);
      word_q = '{5'd0};
      send_word(OP_PREFIX);

      // Random words, with a rare clear on a random letter and end flag.
      random_end = items_sent + RANDOM_ITEMS;
      clears_left = 2;
      while (items_sent < random_end) begin
         if (clears_left > 0 && $urandom_range(0, 119) == 0) begin
            clears_left--;
            send_item(OP_CLEAR, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
         end else begin
            random_word();
         end
      end

      // Long stretch without any idle cycle.
      idle_on = 1'b0;
      random_end = items_sent + NOGAP_ITEMS;
      while (items_sent < random_end) random_word();
      idle_on = 1'b1;

      // A repeated one-letter word: counts, erase down to a cut edge, and
      // erase of a copy that is no longer stored.
      word_q = '{5'd0};
      send_word(OP_INSERT);
      send_word(OP_INSERT);
      send_word(OP_EXACT);
      send_word(OP_PREFIX);
      send_word(OP_ERASE);
      send_word(OP_ERASE);
      send_word(OP_ERASE);
      send_word(OP_EXACT);

      // A word of the full length, then one letter too long.
      make_word(MAX_LEN, 25);
      send_word(OP_INSERT);
      send_word(OP_EXACT);
      make_word(MAX_LEN + 1, 25);
      send_word(OP_INSERT);

      // Clear with the end flag set, then some ordinary traffic.
      send_item(OP_CLEAR, LETTER_W'($urandom_range(0, 31)), 1'b1);
      repeat (TAIL_WORDS) random_word();

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
design/ptc_pkg.sv
design/ptc_ram.sv
design/ptc_word_buf.sv
design/ptc_engine.sv
design/prefix_tree_counter.sv
tb/ptc_trie_checker.sv
tb/prefix_tree_counter_tb.sv
